// ===== design/sigmoid_and_derivative_unit_macros.svh =====
// assertion helpers for the checker file
`ifndef SIGMOID_AND_DERIVATIVE_UNIT_MACROS_SVH
`define SIGMOID_AND_DERIVATIVE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sdu_pkg.sv =====
package sdu_pkg;

  localparam int VALUE_W  = 18;
  localparam int RESULT_W = 16;
  localparam int MODE_W   = 2;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_SIG     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DERIV_Z = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DERIV_A = 2'd2;

  // q1.15 constants
  localparam logic [RESULT_W-1:0] ONE_Q15  = 16'h8000;
  localparam logic [RESULT_W-1:0] ZERO_Q15 = 16'h0000;
  localparam logic [RESULT_W-1:0] HALF_Q15 = 16'h4000;

endpackage

// ===== design/sigmoid_and_derivative_unit.sv =====
// channel   dir  tdata                         tuser
// s_axis    in   [17:0] value, [23:18] zero    [1:0] mode
// m_axis    out  [15:0] result                 [0] clamped
//
// seven register stages; one beat accepted per cycle unless a stalled output has backed up to the input
// the three multiplies and the registered table read each own a stage
// rst is synchronous and clears the stage valid bits only
// a stalled output holds its beat; bubbles inside the pipe are squeezed out,
// so upstream keeps moving until every stage holds a beat
module sigmoid_and_derivative_unit
  import sdu_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [17:0] value, [23:18] zero fill
  input  logic [MODE_W-1:0]   s_axis_tuser,   // [1:0] mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RESULT_W-1:0] m_axis_tdata,   // [15:0] result
  output logic                m_axis_tuser    // [0] clamped
);

  localparam int ADDR_W = $clog2(TABLE_ENTRIES + 1);
  localparam int P_W    = 15 + ADDR_W;
  localparam int NSTG   = 7;

  // table step 8/TABLE_ENTRIES in q31
  localparam logic [63:0] STEP_Q31 = (64'd8 << 31) / 64'(TABLE_ENTRIES);

  typedef logic [RESULT_W-1:0] rom_t [TABLE_ENTRIES+1];

  // shift-subtract division used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // f sampled on [0,8], q1.15, built at elaboration
  function automatic rom_t build_rom();
    logic [63:0] t;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] d;
    longint      sum;
    rom_t        r;
    t   = 64'd1 << 31;
    sum = longint'(64'd1 << 31);
    for (int k = 1; k <= 24; k++) begin
      t = udiv64((t * STEP_Q31) >> 31, 64'(k));
      if (k[0]) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    b = 64'(sum);
    e = 64'd1 << 31;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      if (k > 0) begin
        e = (e * b + (64'd1 << 30)) >> 31;
      end
      d    = (64'd1 << 31) + e;
      r[k] = RESULT_W'(udiv64((64'd1 << 46) + (d >> 1), d));
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  // stage handshake
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: magnitude, range checks, activation clamp
  logic signed [VALUE_W-1:0] v_in;
  logic [VALUE_W-1:0]        u_in;
  logic                      neg_in;
  logic                      sat_in;
  logic [RESULT_W-1:0]       a_in;
  logic                      aclip_in;
  logic                      flg_in;

  always_comb begin
    v_in   = signed'(s_axis_tdata[VALUE_W-1:0]);
    neg_in = v_in[VALUE_W-1];
    u_in   = neg_in ? VALUE_W'(-v_in) : VALUE_W'(v_in);
    sat_in = |u_in[VALUE_W-1:15];
    if (neg_in) begin
      a_in     = ZERO_Q15;
      aclip_in = 1'b1;
    end else if (VALUE_W'(v_in) > VALUE_W'(ONE_Q15)) begin
      a_in     = ONE_Q15;
      aclip_in = 1'b1;
    end else begin
      a_in     = v_in[RESULT_W-1:0];
      aclip_in = 1'b0;
    end
    case (s_axis_tuser)
      MODE_SIG, MODE_DERIV_Z: flg_in = sat_in;
      MODE_DERIV_A:           flg_in = aclip_in;
      default:                flg_in = 1'b0;
    endcase
  end

  logic [MODE_W-1:0]   s1_mode;
  logic                s1_neg;
  logic                s1_sat;
  logic                s1_flg;
  logic [14:0]         s1_u;
  logic [RESULT_W-1:0] s1_a;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_mode <= s_axis_tuser;
      s1_neg  <= neg_in;
      s1_sat  <= sat_in;
      s1_flg  <= flg_in;
      s1_u    <= u_in[14:0];
      s1_a    <= a_in;
    end
  end

  // stage 2: scale magnitude to table position
  logic [MODE_W-1:0]   s2_mode;
  logic                s2_neg;
  logic                s2_sat;
  logic                s2_flg;
  logic [P_W-1:0]      s2_p;
  logic [RESULT_W-1:0] s2_a;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_mode <= s1_mode;
      s2_neg  <= s1_neg;
      s2_sat  <= s1_sat;
      s2_flg  <= s1_flg;
      s2_p    <= P_W'(s1_u) * P_W'(TABLE_ENTRIES);
      s2_a    <= s1_a;
    end
  end

  // stage 3: table read of both neighbors
  logic [ADDR_W-1:0] idx_lo;
  logic [ADDR_W-1:0] idx_hi;

  assign idx_lo = s2_p[P_W-1:15];
  assign idx_hi = idx_lo + ADDR_W'(1);

  logic [MODE_W-1:0]   s3_mode;
  logic                s3_neg;
  logic                s3_sat;
  logic                s3_flg;
  logic [14:0]         s3_frac;
  logic [RESULT_W-1:0] s3_lo;
  logic [RESULT_W-1:0] s3_hi;
  logic [RESULT_W-1:0] s3_a;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_mode <= s2_mode;
      s3_neg  <= s2_neg;
      s3_sat  <= s2_sat;
      s3_flg  <= s2_flg;
      s3_frac <= s2_p[14:0];
      s3_lo   <= SIG_ROM[idx_lo];
      s3_hi   <= SIG_ROM[idx_hi];
      s3_a    <= s2_a;
    end
  end

  // stage 4: slope times fraction
  logic [RESULT_W-1:0] diff3;

  assign diff3 = (s3_hi < s3_lo) ? ZERO_Q15 : s3_hi - s3_lo;

  logic [MODE_W-1:0]   s4_mode;
  logic                s4_neg;
  logic                s4_sat;
  logic                s4_flg;
  logic [30:0]         s4_prod;
  logic [RESULT_W-1:0] s4_lo;
  logic [RESULT_W-1:0] s4_a;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_mode <= s3_mode;
      s4_neg  <= s3_neg;
      s4_sat  <= s3_sat;
      s4_flg  <= s3_flg;
      s4_prod <= 31'(diff3) * 31'(s3_frac);
      s4_lo   <= s3_lo;
      s4_a    <= s3_a;
    end
  end

  // stage 5: finish sigmoid, mirror for negative z, pick derivative operand
  logic [31:0]         rnd4;
  logic [RESULT_W-1:0] fpos4;
  logic [RESULT_W-1:0] sig4;

  always_comb begin
    rnd4 = (32'(s4_prod) + 32'(HALF_Q15)) >> 15;
    if (s4_sat) begin
      fpos4 = ONE_Q15;
    end else begin
      fpos4 = s4_lo + rnd4[RESULT_W-1:0];
    end
    sig4 = s4_neg ? ONE_Q15 - fpos4 : fpos4;
  end

  logic [MODE_W-1:0]   s5_mode;
  logic                s5_flg;
  logic [RESULT_W-1:0] s5_sig;
  logic [RESULT_W-1:0] s5_a;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_mode <= s4_mode;
      s5_flg  <= s4_flg;
      s5_sig  <= sig4;
      s5_a    <= (s4_mode == MODE_DERIV_Z) ? sig4 : s4_a;
    end
  end

  // stage 6: a * (1 - a)
  logic [RESULT_W-1:0] comp5;

  assign comp5 = ONE_Q15 - s5_a;

  logic [MODE_W-1:0]   s6_mode;
  logic                s6_flg;
  logic [RESULT_W-1:0] s6_sig;
  logic [28:0]         s6_prod;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_mode <= s5_mode;
      s6_flg  <= s5_flg;
      s6_sig  <= s5_sig;
      s6_prod <= 29'(32'(s5_a) * 32'(comp5));
    end
  end

  // stage 7: round and select the output beat
  logic [31:0]         rnd6;
  logic [RESULT_W-1:0] res6;

  always_comb begin
    rnd6 = (32'(s6_prod) + 32'(HALF_Q15)) >> 15;
    case (s6_mode)
      MODE_SIG:                   res6 = s6_sig;
      MODE_DERIV_Z, MODE_DERIV_A: res6 = rnd6[RESULT_W-1:0];
      default:                    res6 = ZERO_Q15;
    endcase
  end

  logic [RESULT_W-1:0] s7_res;
  logic                s7_flg;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_res <= res6;
      s7_flg <= s6_flg;
    end
  end

  assign m_axis_tvalid = vld[NSTG];
  assign m_axis_tdata  = s7_res;
  assign m_axis_tuser  = s7_flg;

endmodule

// ===== design/sdu_checker.sv =====
`include "sigmoid_and_derivative_unit_macros.svh"

module sdu_checker
  import sdu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [RESULT_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // a stalled output beat holds
  `SDU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed under stall")

  // results never exceed 1.0
  `SDU_ASSERT_SAME(a_out_range, m_axis_tvalid, m_axis_tdata <= ONE_Q15, "result above 1.0")

  // an empty output stage means the whole pipe can take a beat
  `SDU_ASSERT_SAME(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // downstream ready propagates to the input side
  `SDU_ASSERT_SAME(a_ready_pass, m_axis_tready, s_axis_tready, "input stalled while output drains")

endmodule

bind sigmoid_and_derivative_unit sdu_checker u_sdu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
